// ===== sv/sipmb_pkg.sv =====
// Package for the sorted insert / pop-max buffer.
// Holds field widths, operation and status codes and the cell control struct.
// No dependencies.
package sipmb_pkg;

    localparam int KEY_W    = 16;
    localparam int TAG_W    = 16;
    localparam int STATUS_W = 2;
    localparam int RANK_W   = 4;
    localparam int FILL_W   = 5;

    // Stream widths, fields packed from bit 0 and padded to whole bytes.
    localparam int IN_BITS   = 1 + KEY_W + TAG_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = STATUS_W + KEY_W + TAG_W + RANK_W + FILL_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_DROPPED   = 2'd1,
        ST_POPPED    = 2'd2,
        ST_POP_EMPTY = 2'd3
    } t_status;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic ins;  // sorted insert of the new entry
        logic pop;  // shift everything toward cell 0
    } t_cell_ctl;

endpackage

// ===== sv/sorted_insert_pop_max_buffer.sv =====
// Top level of the sorted insert / pop-max buffer: cell chain, fill count, result register.
// Depends on sipmb_pkg and sipmb_cell.
//
//  Channel  | Dir | tdata fields, low bit first                         | tlast/tuser
//  s_axis   | in  | operation[0] key[16:1] tag[32:17], pad to 40        | none
//  m_axis   | out | status[1:0] out_key[17:2] out_tag[33:18]            | none
//           |     | out_rank[37:34] fill_level[42:38], pad to 48        |
//
// One transaction per cycle while the result is not stalled: every cell compares its key with the new one and
// shifts in parallel, so an insert or a pop finishes in the accept cycle.
// The result register loads at the accepting edge; the result is offered from the next cycle.
// Reset (synchronous, active low) clears the fill count and the result valid;
// cell contents are not reset and are only read below the fill count.
// A stalled result holds s_axis_tready low while m_axis_tready is low.
module sorted_insert_pop_max_buffer #(
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // operation, key, tag
    input  logic [sipmb_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // status, out_key, out_tag, out_rank, fill_level
    output logic [sipmb_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import sipmb_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Input field unpack.
    t_op              w_op;
    logic [KEY_W-1:0] w_key;
    logic [TAG_W-1:0] w_tag;
    assign w_op  = t_op'(s_axis_tdata[0]);
    assign w_key = s_axis_tdata[KEY_W:1];
    assign w_tag = s_axis_tdata[KEY_W+TAG_W:KEY_W+1];

    logic             w_accept;
    logic             w_full;
    logic             w_empty;
    t_cell_ctl        w_ctl;
    logic [CNT_W-1:0] r_count, n_count;

    assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_full        = (r_count == CNT_W'(DEPTH));
    assign w_empty       = (r_count == '0);

    always_comb begin
        w_ctl.ins = w_accept && (w_op == OP_INSERT) && !w_full;
        w_ctl.pop = w_accept && (w_op == OP_REMOVE) && !w_empty;
    end

    // Cell chain, kept in descending key order: cell 0 holds the largest key,
    // and among equal keys the newest one sits closest to cell 0.
    logic [KEY_W-1:0] w_cell_key [DEPTH];
    logic [TAG_W-1:0] w_cell_tag [DEPTH];
    logic             w_cell_le  [DEPTH];

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic             w_left_le;
        logic [KEY_W-1:0] w_left_key, w_right_key;
        logic [TAG_W-1:0] w_left_tag, w_right_tag;

        if (gi == 0) begin : g_head
            assign w_left_le  = 1'b0;
            assign w_left_key = '0;
            assign w_left_tag = '0;
        end else begin : g_mid
            assign w_left_le  = w_cell_le[gi-1];
            assign w_left_key = w_cell_key[gi-1];
            assign w_left_tag = w_cell_tag[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            // Vacated on pop; contents beyond the fill count are never read.
            assign w_right_key = '0;
            assign w_right_tag = '0;
        end else begin : g_body
            assign w_right_key = w_cell_key[gi+1];
            assign w_right_tag = w_cell_tag[gi+1];
        end

        sipmb_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_new_key   (w_key),
            .i_new_tag   (w_tag),
            .i_occupied  (CNT_W'(gi) < r_count),
            .i_at_end    (CNT_W'(gi) == r_count),
            .i_left_le   (w_left_le),
            .i_left_key  (w_left_key),
            .i_left_tag  (w_left_tag),
            .i_right_key (w_right_key),
            .i_right_tag (w_right_tag),
            .o_le        (w_cell_le[gi]),
            .o_key       (w_cell_key[gi]),
            .o_tag       (w_cell_tag[gi])
        );
    end

    // Fill count.
    always_comb begin
        n_count = r_count;
        if (w_ctl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Result register.
    logic              r_out_valid;
    t_status           r_status,  n_status;
    logic [KEY_W-1:0]  r_out_key, n_out_key;
    logic [TAG_W-1:0]  r_out_tag, n_out_tag;
    logic [RANK_W-1:0] r_rank,    n_rank;
    logic [FILL_W-1:0] r_fill;

    always_comb begin
        n_status  = ST_INSERTED;
        n_out_key = '0;
        n_out_tag = '0;
        n_rank    = '0;
        if (w_op == OP_INSERT) begin
            n_status = w_full ? ST_DROPPED : ST_INSERTED;
        end else if (w_empty) begin
            n_status = ST_POP_EMPTY;
        end else begin
            // Top of the queue is always cell 0; its rank is the count left.
            n_status  = ST_POPPED;
            n_out_key = w_cell_key[0];
            n_out_tag = w_cell_tag[0];
            n_rank    = RANK_W'(r_count - CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status  <= n_status;
            r_out_key <= n_out_key;
            r_out_tag <= n_out_tag;
            r_rank    <= n_rank;
            r_fill    <= FILL_W'(n_count);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_DATA_W - OUT_BITS)'(0), r_fill, r_rank,
                            r_out_tag, r_out_key, r_status};

endmodule

// ===== sv/sipmb_cell.sv =====
// One storage cell of the sorted buffer chain: a key/tag pair and its shift logic.
// Depends on sipmb_pkg.
module sipmb_cell (
    input  logic                      i_clk,
    input  sipmb_pkg::t_cell_ctl      i_ctl,
    input  logic [sipmb_pkg::KEY_W-1:0] i_new_key,
    input  logic [sipmb_pkg::TAG_W-1:0] i_new_tag,
    input  logic                      i_occupied,  // cell holds a live entry
    input  logic                      i_at_end,    // first free cell
    input  logic                      i_left_le,   // left neighbor shifts right
    input  logic [sipmb_pkg::KEY_W-1:0] i_left_key,
    input  logic [sipmb_pkg::TAG_W-1:0] i_left_tag,
    input  logic [sipmb_pkg::KEY_W-1:0] i_right_key,
    input  logic [sipmb_pkg::TAG_W-1:0] i_right_tag,
    output logic                      o_le,        // live and key <= new key
    output logic [sipmb_pkg::KEY_W-1:0] o_key,
    output logic [sipmb_pkg::TAG_W-1:0] o_tag
);
    import sipmb_pkg::*;

    logic [KEY_W-1:0] r_key, n_key;
    logic [TAG_W-1:0] r_tag, n_tag;

    assign o_le  = i_occupied && (r_key <= i_new_key);
    assign o_key = r_key;
    assign o_tag = r_tag;

    always_comb begin
        n_key = r_key;
        n_tag = r_tag;
        if (i_ctl.ins) begin
            if (i_left_le) begin
                n_key = i_left_key;
                n_tag = i_left_tag;
            end else if (o_le || i_at_end) begin
                n_key = i_new_key;
                n_tag = i_new_tag;
            end
        end else if (i_ctl.pop) begin
            n_key = i_right_key;
            n_tag = i_right_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_tag <= n_tag;
    end

endmodule
